@@ rtl/tes_pkg.sv @@
package tes_pkg;

   localparam int DEFAULT_TAB_WIDTH = 8;
   localparam int MAX_STOPS = 6;
   localparam int COLUMN_MAX = 4095;

   localparam int NUM_STOPS = 6;
   localparam int STOP_W = 12;
   localparam int COUNT_W = 3;
   localparam int BYTE_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int RUN_LIMIT = 64;
   localparam int RUN_W = 7;

   localparam logic [BYTE_W-1:0] CH_TAB = 8'd9;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_A = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_B = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_C = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_D = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_E = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_F = 3'd6;

   typedef logic [STOP_W-1:0] stop_type;

   // programmed stops with their quotients by the default width
   typedef struct packed {
      logic [COUNT_W-1:0] stop_count;
      stop_type [NUM_STOPS-1:0] stop;
      stop_type [NUM_STOPS-1:0] quot;
   } csr_type;

endpackage

@@ rtl/tes_req_if.sv @@
interface tes_req_if;
   logic valid;
   logic ready;
   logic [tes_pkg::BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/tes_rsp_if.sv @@
interface tes_rsp_if;
   logic valid;
   logic ready;
   logic [tes_pkg::BYTE_W-1:0] out_byte;
   logic last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ rtl/tes_csr.sv @@
module tes_csr #(
   parameter int DEFAULT_TAB_WIDTH = tes_pkg::DEFAULT_TAB_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [tes_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tes_pkg::CSR_DATA_W-1:0] csr_data,
   output tes_pkg::csr_type csr_out
);

   localparam int SHIFT_W = (DEFAULT_TAB_WIDTH > 1) ? $clog2(DEFAULT_TAB_WIDTH) : 0;
   localparam int SH = tes_pkg::STOP_W + SHIFT_W;
   localparam int RECIP = ((1 << SH) + DEFAULT_TAB_WIDTH - 1) / DEFAULT_TAB_WIDTH;
   localparam int RECIP_W = tes_pkg::STOP_W + 2;
   localparam int PROD_W = tes_pkg::STOP_W + RECIP_W;

   logic [tes_pkg::COUNT_W-1:0] stop_count_ff, stop_count_in;
   tes_pkg::stop_type [tes_pkg::NUM_STOPS-1:0] stop_ff, stop_in;
   tes_pkg::stop_type [tes_pkg::NUM_STOPS-1:0] quot_ff, quot_in;

   always_comb begin
      stop_count_in = stop_count_ff;
      stop_in = stop_ff;
      if (csr_we) begin
         unique case (csr_index)
            tes_pkg::CSR_STOP_COUNT: stop_count_in = csr_data[tes_pkg::COUNT_W-1:0];
            tes_pkg::CSR_STOP_A: stop_in[0] = csr_data;
            tes_pkg::CSR_STOP_B: stop_in[1] = csr_data;
            tes_pkg::CSR_STOP_C: stop_in[2] = csr_data;
            tes_pkg::CSR_STOP_D: stop_in[3] = csr_data;
            tes_pkg::CSR_STOP_E: stop_in[4] = csr_data;
            tes_pkg::CSR_STOP_F: stop_in[5] = csr_data;
            default: ;
         endcase
      end
   end

   // quotient by reciprocal multiply, exact over the whole stop range
   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int i = 0; i < tes_pkg::NUM_STOPS; i++) begin
         prod = PROD_W'(stop_ff[i]) * PROD_W'(RECIP_W'(RECIP));
         quot_in[i] = tes_pkg::STOP_W'(prod >> SH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         stop_ff <= '0;
         quot_ff <= '0;
      end else begin
         stop_count_ff <= stop_count_in;
         stop_ff <= stop_in;
         quot_ff <= quot_in;
      end
   end

   assign csr_out.stop_count = stop_count_ff;
   assign csr_out.stop = stop_ff;
   assign csr_out.quot = quot_ff;

endmodule

@@ rtl/tes_stop_find.sv @@
module tes_stop_find #(
   parameter int DEFAULT_TAB_WIDTH = tes_pkg::DEFAULT_TAB_WIDTH,
   parameter int MAX_STOPS = tes_pkg::MAX_STOPS,
   parameter int COLUMN_MAX = tes_pkg::COLUMN_MAX,
   localparam int COL_W = $clog2(COLUMN_MAX + 1),
   localparam int REM_W = (DEFAULT_TAB_WIDTH > 1) ? $clog2(DEFAULT_TAB_WIDTH) : 1
) (
   input  tes_pkg::csr_type csr,
   input  logic [COL_W-1:0] column,
   input  logic [REM_W-1:0] rem,
   output logic [COL_W-1:0] next_column,
   output logic [REM_W-1:0] next_rem,
   output logic [tes_pkg::RUN_W-1:0] run
);

   localparam int CMP_W = (COL_W > tes_pkg::STOP_W) ? COL_W : tes_pkg::STOP_W;
   localparam int TGT_W = CMP_W + 1;
   localparam int CMAX_REM = COLUMN_MAX % DEFAULT_TAB_WIDTH;

   logic [tes_pkg::COUNT_W-1:0] used;
   logic [TGT_W-1:0] col_ext;
   logic [TGT_W-1:0] target;
   logic [TGT_W-1:0] run_full;
   logic found;
   tes_pkg::stop_type found_stop;
   logic [REM_W-1:0] found_rem;

   assign col_ext = TGT_W'(column);
   assign used = (csr.stop_count > tes_pkg::COUNT_W'(MAX_STOPS)) ?
                 tes_pkg::COUNT_W'(MAX_STOPS) : csr.stop_count;

   // first stop above the column and not below the stop before it
   always_comb begin
      tes_pkg::stop_type prev_stop;
      tes_pkg::stop_type prod;
      tes_pkg::stop_type diff;
      found = 1'b0;
      found_stop = '0;
      found_rem = '0;
      prev_stop = '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         prod = tes_pkg::STOP_W'(csr.quot[i] * tes_pkg::STOP_W'(DEFAULT_TAB_WIDTH));
         diff = csr.stop[i] - prod;
         if (!found && (tes_pkg::COUNT_W'(i) < used) &&
             (col_ext < TGT_W'(csr.stop[i])) && (col_ext >= TGT_W'(prev_stop))) begin
            found = 1'b1;
            found_stop = csr.stop[i];
            found_rem = diff[REM_W-1:0];
         end
         prev_stop = csr.stop[i];
      end
   end

   assign target = found ? TGT_W'(found_stop) :
                   col_ext - TGT_W'(rem) + TGT_W'(DEFAULT_TAB_WIDTH);
   assign run_full = target - col_ext;

   always_comb begin
      if (target > TGT_W'(COLUMN_MAX)) begin
         next_column = COL_W'(COLUMN_MAX);
         next_rem = REM_W'(CMAX_REM);
      end else begin
         next_column = target[COL_W-1:0];
         next_rem = found ? found_rem : '0;
      end
      if (run_full > TGT_W'(tes_pkg::RUN_LIMIT)) begin
         run = tes_pkg::RUN_W'(tes_pkg::RUN_LIMIT);
      end else if (run_full == '0) begin
         run = tes_pkg::RUN_W'(1);
      end else begin
         run = run_full[tes_pkg::RUN_W-1:0];
      end
   end

endmodule

@@ rtl/tab_expander_custom_stops_core.sv @@
// tab expander with programmable tab stops
// req_if carries one byte per transfer, rsp_if one output byte per transfer
// with last_of_run high on the final byte that a request byte produces
// a tab gives a run of 1 to 64 spaces up to the next stop, any other byte
// passes through once; newline returns the column to zero
// stops and their count are written on the csr port (index 0 count, 1 to 6
// the stops); the user must write them only while the block holds no
// work, which the block itself does not enforce
// a byte taken on req_if goes through the input register, then the result
// register; throughput: one byte per cycle for plain bytes while rsp_if
// is ready; a tab holds the result register until its whole run has
// left, while the input register still takes the next byte
// a stalled rsp_if holds the result register and its byte; req_if.ready
// drops once the input register is also full
// reset (synchronous) empties both registers and clears the column, the
// stop count and all stops
module tab_expander_custom_stops_core #(
   parameter int DEFAULT_TAB_WIDTH = tes_pkg::DEFAULT_TAB_WIDTH,
   parameter int MAX_STOPS = tes_pkg::MAX_STOPS,
   parameter int COLUMN_MAX = tes_pkg::COLUMN_MAX
) (
   input  logic clock,
   input  logic reset,
   tes_req_if.sink req_if,
   tes_rsp_if.source rsp_if,
   input  logic csr_we,
   input  logic [tes_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tes_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(COLUMN_MAX + 1);
   localparam int REM_W = (DEFAULT_TAB_WIDTH > 1) ? $clog2(DEFAULT_TAB_WIDTH) : 1;

   tes_pkg::csr_type csr;

   logic s1_valid_ff, s1_valid_in;
   logic [tes_pkg::BYTE_W-1:0] s1_byte_ff, s1_byte_in;
   logic s2_valid_ff, s2_valid_in;
   logic [tes_pkg::BYTE_W-1:0] s2_byte_ff, s2_byte_in;
   logic [tes_pkg::RUN_W-1:0] s2_count_ff, s2_count_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [REM_W-1:0] rem_ff, rem_in;

   logic [COL_W-1:0] tab_column;
   logic [REM_W-1:0] tab_rem;
   logic [tes_pkg::RUN_W-1:0] tab_run;

   logic s2_last;
   logic s2_free;
   logic s1_move;
   logic req_take;
   logic is_tab;

   tes_csr #(
      .DEFAULT_TAB_WIDTH(DEFAULT_TAB_WIDTH)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .csr_out(csr)
   );

   tes_stop_find #(
      .DEFAULT_TAB_WIDTH(DEFAULT_TAB_WIDTH),
      .MAX_STOPS(MAX_STOPS),
      .COLUMN_MAX(COLUMN_MAX)
   ) u_stop_find (
      .csr(csr),
      .column(column_ff),
      .rem(rem_ff),
      .next_column(tab_column),
      .next_rem(tab_rem),
      .run(tab_run)
   );

   assign s2_last = (s2_count_ff == tes_pkg::RUN_W'(1));
   assign s2_free = !s2_valid_ff || (rsp_if.ready && s2_last);
   assign s1_move = s1_valid_ff && s2_free;
   assign req_if.ready = !s1_valid_ff || s2_free;
   assign req_take = req_if.valid && req_if.ready;
   assign is_tab = (s1_byte_ff == tes_pkg::CH_TAB);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in = s1_byte_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in = req_if.in_byte;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_byte_in = s2_byte_ff;
      s2_count_in = s2_count_ff;
      column_in = column_ff;
      rem_in = rem_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         if (is_tab) begin
            s2_byte_in = tes_pkg::CH_SPACE;
            s2_count_in = tab_run;
            column_in = tab_column;
            rem_in = tab_rem;
         end else begin
            s2_byte_in = s1_byte_ff;
            s2_count_in = tes_pkg::RUN_W'(1);
            if (s1_byte_ff == tes_pkg::CH_NEWLINE) begin
               column_in = '0;
               rem_in = '0;
            end else if (column_ff < COL_W'(COLUMN_MAX)) begin
               column_in = column_ff + COL_W'(1);
               rem_in = (rem_ff == REM_W'(DEFAULT_TAB_WIDTH - 1)) ? '0 : rem_ff + REM_W'(1);
            end
         end
      end else if (s2_valid_ff && rsp_if.ready) begin
         if (s2_last) begin
            s2_valid_in = 1'b0;
         end else begin
            s2_count_in = s2_count_ff - tes_pkg::RUN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         column_ff <= '0;
         rem_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         column_ff <= column_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s2_byte_ff <= s2_byte_in;
      s2_count_ff <= s2_count_in;
   end

   assign rsp_if.valid = s2_valid_ff;
   assign rsp_if.out_byte = s2_byte_ff;
   assign rsp_if.last_of_run = s2_last;

endmodule

@@ rtl/tes_checker.sv @@
module tes_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [tes_pkg::BYTE_W-1:0] out_byte,
   input logic last_of_run
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last_of_run))
      else $error("stalled result changed");

   // only spaces of a tab run can be followed by more output of the same byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_byte != tes_pkg::CH_SPACE) |-> last_of_run)
      else $error("non-space byte not marked last");

   // a run in progress keeps going
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_of_run |=> rsp_valid)
      else $error("tab run cut short");

   // the input is held off only behind a result that cannot leave
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !(rsp_ready && last_of_run))
      else $error("input held off without a stalled result");

   // reset empties the output
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind tab_expander_custom_stops_core tes_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .out_byte(rsp_if.out_byte),
   .last_of_run(rsp_if.last_of_run)
);

@@ verif/tab_expansion_checker.sv @@
module tab_expansion_checker
   import tes_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tes_req_if req_mon,
   tes_rsp_if rsp_mon,
   input  logic csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int fail_count,
   output int pending_count
);

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic last_of_run;
   } out_char_type;

   out_char_type expected_chars[$];
   logic [COUNT_W-1:0] stops_used = '0;
   stop_type tab_stops[NUM_STOPS];
   int column = 0;
   int errors = 0;

   initial begin
      fail_count = 0;
      pending_count = 0;
      foreach (tab_stops[i]) tab_stops[i] = '0;
   end

   function automatic int next_tab_target(int col);
      int limit;
      int prev;
      limit = (stops_used > MAX_STOPS) ? MAX_STOPS : int'(stops_used);
      prev = 0;
      for (int i = 0; i < limit; i++) begin
         if (col < int'(tab_stops[i]) && col >= prev) begin
            return int'(tab_stops[i]);
         end
         prev = int'(tab_stops[i]);
      end
      return (col / DEFAULT_TAB_WIDTH + 1) * DEFAULT_TAB_WIDTH;
   endfunction

   task automatic expand_byte(logic [BYTE_W-1:0] b);
      int target;
      int run;
      out_char_type c;
      if (b == CH_TAB) begin
         target = next_tab_target(column);
         run = target - column;
         if (run > RUN_LIMIT) run = RUN_LIMIT;
         if (run < 1) run = 1;
         for (int k = 0; k < run; k++) begin
            c.out_byte = CH_SPACE;
            c.last_of_run = (k == run - 1);
            expected_chars.push_back(c);
         end
         column = (target > COLUMN_MAX) ? COLUMN_MAX : target;
      end else begin
         c.out_byte = b;
         c.last_of_run = 1'b1;
         expected_chars.push_back(c);
         if (b == CH_NEWLINE) column = 0;
         else if (column < COLUMN_MAX) column = column + 1;
      end
   endtask

   task automatic report(string what, int got, int want);
      errors++;
      $display("mismatch: %s, got %0d, expected %0d, at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin
      out_char_type want;
      if (reset) begin
         stops_used = '0;
         foreach (tab_stops[i]) tab_stops[i] = '0;
         column = 0;
         expected_chars.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_STOP_COUNT) begin
               stops_used = csr_data[COUNT_W-1:0];
            end else if (csr_index >= CSR_STOP_A && csr_index <= CSR_STOP_F) begin
               tab_stops[csr_index - CSR_STOP_A] = csr_data[STOP_W-1:0];
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_chars.size() == 0) begin
               report("output transfer with nothing expected", rsp_mon.out_byte, -1);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_mon.out_byte !== want.out_byte)
                  report("out_byte", rsp_mon.out_byte, want.out_byte);
               if (rsp_mon.last_of_run !== want.last_of_run)
                  report("last_of_run", rsp_mon.last_of_run, want.last_of_run);
            end
         end
         if (req_mon.valid && req_mon.ready) expand_byte(req_mon.in_byte);
      end
      fail_count <= errors;
      pending_count <= expected_chars.size();
   end

endmodule

@@ verif/tab_expander_custom_stops_core_test.sv @@
module tab_expander_custom_stops_core_test;
   import tes_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_NONE = 3'd7;
   localparam int IDLE_PERCENT = 37;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   tes_req_if req_bus ();
   tes_rsp_if rsp_bus ();

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int hold_left = 0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int stop_plan[NUM_STOPS];

   initial begin
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      rsp_bus.ready = 1'b0;
   end

   always #6 clock = ~clock;

   tab_expander_custom_stops_core DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   tab_expansion_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // receiver with random stalls and long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_done) begin
         holds_done <= holds_done + 1;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_steady) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_byte(logic [BYTE_W-1:0] b);
      while (!req_steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic program_stops(int count);
      write_csr(CSR_STOP_COUNT, count);
      for (int i = 0; i < NUM_STOPS; i++) begin
         write_csr(CSR_INDEX_W'(CSR_STOP_A + i), stop_plan[i]);
      end
      write_csr(CSR_NONE, $urandom_range(4095));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pick_random_stops();
      int mode;
      int acc;
      mode = $urandom_range(3);
      acc = $urandom_range(10);
      for (int i = 0; i < NUM_STOPS; i++) begin
         if (mode == 0) begin
            stop_plan[i] = $urandom_range(4095);
         end else if (mode == 1) begin
            stop_plan[i] = $urandom_range(60);
         end else begin
            acc = acc + $urandom_range(24, 1);
            stop_plan[i] = acc;
         end
      end
      program_stops($urandom_range(7));
   endtask

   task automatic send_text(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 22) send_byte(CH_TAB);
         else if (r < 30) send_byte(CH_NEWLINE);
         else send_byte(BYTE_W'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stops after reset: default width only
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_TAB);
      send_byte(8'h41);
      send_byte(CH_TAB);
      send_byte(CH_NEWLINE);
      send_byte(CH_TAB);
      send_byte(CH_TAB);
      wait_drained();

      // count above the list, far stop: clipped runs and saturated column
      stop_plan = '{4095, 4095, 0, 0, 0, 0};
      program_stops(7);
      hold_requests <= hold_requests + 1;
      send_byte(CH_TAB);
      send_byte(8'h78);
      send_byte(CH_TAB);
      send_byte(CH_NEWLINE);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(CH_TAB);
      wait_drained();

      // stops out of order
      stop_plan = '{3, 10, 2, 40, 40, 100};
      program_stops(6);
      send_byte(8'h61);
      send_byte(CH_TAB);
      send_byte(CH_TAB);
      send_byte(CH_TAB);
      send_byte(CH_TAB);
      send_byte(CH_TAB);
      send_byte(CH_NEWLINE);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_random_stops();
         req_steady = (phase == 1);
         rsp_steady <= (phase == 1);
         if (phase == 2) begin
            send_text(PHASE_ITEMS / 2);
            hold_requests <= hold_requests + 1;
            send_text(PHASE_ITEMS / 2);
         end else if (phase == 3) begin
            send_text(PHASE_ITEMS / 2);
            wait_drained();
            send_text(PHASE_ITEMS / 2);
         end else begin
            send_text(PHASE_ITEMS);
         end
         wait_drained();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ tab_expander_custom_stops_core.f @@
rtl/tes_pkg.sv
rtl/tes_req_if.sv
rtl/tes_rsp_if.sv
rtl/tes_csr.sv
rtl/tes_stop_find.sv
rtl/tab_expander_custom_stops_core.sv
rtl/tes_checker.sv
verif/tab_expansion_checker.sv
verif/tab_expander_custom_stops_core_test.sv
